[rtl/pee_pkg.sv]
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned PtrW       = $clog2(StackDepth);
  localparam int unsigned CntW       = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    ErrNone      = 3'd0,
    ErrUnderflow = 3'd1,
    ErrDivZero   = 3'd2,
    ErrBadChar   = 3'd3,
    ErrCount     = 3'd4,
    ErrOverflow  = 3'd5,
    ErrTooBig    = 3'd6
  } err_e;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChMul   = 8'h2A;
  localparam logic [7:0] ChDiv   = 8'h2F;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

[rtl/pee_stack_ram.sv]
// ----------------------------------------------------------------------------
// pee_stack_ram
// Operand stack memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module pee_stack_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [pee_pkg::PtrW-1:0]  waddr_i,
  input  logic [31:0]               wdata_i,
  input  logic [pee_pkg::PtrW-1:0]  raddr_a_i,
  input  logic [pee_pkg::PtrW-1:0]  raddr_b_i,
  output logic [31:0]               rdata_a_o,
  output logic [31:0]               rdata_b_o
);
  import pee_pkg::*;

  logic [31:0] mem [StackDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

[rtl/pee_divider.sv]
// ----------------------------------------------------------------------------
// pee_divider
// Signed 32-bit restoring divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module pee_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pee_pkg::div_req_t req_i,
  output pee_pkg::div_rsp_t rsp_o
);
  import pee_pkg::*;

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q, quo_q, dvs_q;
  logic        neg_q;
  logic [32:0] trial;

  assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rsp_o  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      rsp_o.done <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= req_i.dividend[31] ? 32'd0 - req_i.dividend : req_i.dividend;
        dvs_q  <= req_i.divisor[31] ? 32'd0 - req_i.divisor : req_i.divisor;
        neg_q  <= req_i.dividend[31] ^ req_i.divisor[31];
      end else if (busy_q) begin
        if (cnt_q == 6'd32) begin
          busy_q         <= 1'b0;
          rsp_o.done     <= 1'b1;
          rsp_o.quotient <= neg_q ? 32'd0 - quo_q : quo_q;
        end else begin
          cnt_q <= cnt_q + 6'd1;
          // one quotient bit per cycle
          if (!trial[32]) begin
            rem_q <= trial[31:0];
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= {rem_q[30:0], quo_q[31]};
            quo_q <= {quo_q[30:0], 1'b0};
          end
        end
      end
    end
  end

endmodule

[rtl/postfix_expression_evaluator_unit.sv]
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// Postfix expression evaluator over a 64-entry operand stack memory.
// ----------------------------------------------------------------------------
// Digits, spaces and characters after an error are handled in the idle
// state. An operator is accepted, two stack entries are read from the memory,
// then the result is computed and written back; a '/' with a zero divisor
// ends there, any other '/' waits for the bit-serial divider. The end marker
// passes StEndRead and StEndOut, and the result appears on registered outputs
// in the cycle after. Characters are still accepted while an earlier result
// waits to be taken. A further end marker waits until that result has gone.
module postfix_expression_evaluator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic [2:0]  error_code_o,
  output logic signed [31:0] top_value_o
);
  import pee_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StOpRead, StOpExec, StDivWait, StEndRead, StEndOut
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic [30:0]     acc_q;
  logic            pend_q;
  err_e            err_q;
  logic [7:0]      opc_q;

  logic            we;
  logic [PtrW-1:0] waddr, ra, rb;
  logic [31:0]     wdata, rda, rdb;
  div_req_t        dreq;
  div_rsp_t        drsp;

  pee_stack_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_a_i(ra), .raddr_b_i(rb), .rdata_a_o(rda), .rdata_b_o(rdb)
  );

  pee_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic        accept;
  logic        is_digit, is_op;
  logic [34:0] acc_next;
  logic        push_ok;

  assign in_ready_o = (state_q == StIdle) && !(out_valid_o && !out_ready_i && op_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_digit   = (char_code_i >= ChZero) && (char_code_i <= ChNine);
  assign is_op      = (char_code_i == ChPlus) || (char_code_i == ChMinus) ||
                      (char_code_i == ChMul) || (char_code_i == ChDiv);
  assign acc_next   = {acc_q, 3'b0} + {2'b0, acc_q, 1'b0} +
                      {31'd0, char_code_i[3:0] - ChZero[3:0]};
  assign push_ok    = cnt_q < CntW'(StackDepth);

  // lhs at count-2, rhs at count-1
  assign ra = PtrW'(cnt_q - CntW'(2));
  assign rb = (state_q == StIdle && op_i) ? '0 : PtrW'(cnt_q - CntW'(1));

  always_comb begin
    we    = 1'b0;
    waddr = PtrW'(cnt_q);
    wdata = {1'b0, acc_q};
    dreq  = '{start: 1'b0, dividend: rda, divisor: rdb};
    if (state_q == StIdle && accept && err_q == ErrNone && pend_q && push_ok &&
        (op_i || char_code_i == ChSpace)) begin
      we = 1'b1;
    end
    if (state_q == StOpExec && !(opc_q == ChDiv)) begin
      we    = 1'b1;
      waddr = PtrW'(cnt_q - CntW'(2));
      case (opc_q)
        ChPlus:  wdata = rda + rdb;
        ChMinus: wdata = rda - rdb;
        default: wdata = rda * rdb;
      endcase
    end
    if (state_q == StOpExec && opc_q == ChDiv && rdb != 32'd0) dreq.start = 1'b1;
    if (state_q == StDivWait && drsp.done) begin
      we    = 1'b1;
      waddr = PtrW'(cnt_q - CntW'(2));
      wdata = drsp.quotient;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      acc_q        <= '0;
      pend_q       <= 1'b0;
      err_q        <= ErrNone;
      opc_q        <= '0;
      out_valid_o  <= 1'b0;
      valid_res_o  <= 1'b0;
      error_code_o <= '0;
      top_value_o  <= '0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (op_i) begin
              // pending push at end
              if (err_q == ErrNone && pend_q) begin
                if (push_ok) cnt_q <= cnt_q + CntW'(1);
                else err_q <= ErrOverflow;
              end
              state_q <= StEndRead;
            end else if (err_q == ErrNone) begin
              if (is_digit) begin
                if (acc_q > 31'd214748364 || acc_next > 35'h7FFFFFFF) begin
                  err_q <= ErrTooBig;
                end else begin
                  acc_q  <= acc_next[30:0];
                  pend_q <= 1'b1;
                end
              end else if (char_code_i == ChSpace) begin
                if (pend_q) begin
                  if (push_ok) cnt_q <= cnt_q + CntW'(1);
                  else err_q <= ErrOverflow;
                  acc_q  <= '0;
                  pend_q <= 1'b0;
                end
              end else if (is_op) begin
                if (cnt_q < CntW'(2)) err_q <= ErrUnderflow;
                else begin
                  opc_q   <= char_code_i;
                  state_q <= StOpRead;
                end
              end else begin
                err_q <= ErrBadChar;
              end
            end
          end
        end
        StOpRead: state_q <= StOpExec;
        StOpExec: begin
          if (opc_q == ChDiv) begin
            if (rdb == 32'd0) begin
              err_q   <= ErrDivZero;
              state_q <= StIdle;
            end else state_q <= StDivWait;
          end else begin
            cnt_q   <= cnt_q - CntW'(1);
            state_q <= StIdle;
          end
        end
        StDivWait: begin
          if (drsp.done) begin
            cnt_q   <= cnt_q - CntW'(1);
            state_q <= StIdle;
          end
        end
        StEndRead: state_q <= StEndOut;
        StEndOut: begin
          out_valid_o <= 1'b1;
          if (err_q == ErrNone && cnt_q == CntW'(1)) begin
            valid_res_o  <= 1'b1;
            error_code_o <= ErrNone;
            top_value_o  <= rdb;
          end else begin
            valid_res_o  <= 1'b0;
            error_code_o <= (err_q == ErrNone) ? ErrCount : err_q;
            top_value_o  <= '0;
          end
          cnt_q   <= '0;
          acc_q   <= '0;
          pend_q  <= 1'b0;
          err_q   <= ErrNone;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

[rtl/pee_checker.sv]
// ----------------------------------------------------------------------------
// pee_checker
// Port-level checks on the postfix expression evaluator.
// ----------------------------------------------------------------------------
module pee_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        valid_res_o,
  input logic [2:0]  error_code_o,
  input logic [31:0] top_value_o
);
  import pee_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(top_value_o))
    else $error("result dropped while stalled");

  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |-> error_code_o == ErrNone)
    else $error("valid result with error code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> top_value_o == 32'd0 && error_code_o != ErrNone)
    else $error("invalid result carries value");

endmodule

bind postfix_expression_evaluator_unit pee_checker u_pee_checker (.*);
